>>> rtl/assert_macros.svh
// Assertion macros shared by the vertex transform RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define VMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define VMT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

>>> rtl/vmt_pkg.sv
// Types, constants and register codes of the vertex matrix transform.
package vmt_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned PAIR_W    = PROD_W + 1;
  localparam int unsigned SUM_W     = PROD_W + 2;
  localparam int unsigned CFG_W     = 2 * DATA_W;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned SEL_W     = $clog2(NUM_REGS);
  localparam int unsigned IDX_W     = SEL_W + 1;
  localparam int unsigned DIM       = 4;

  localparam logic [DATA_W-1:0] FIX_ONE      = DATA_W'(1) << FRAC_BITS;
  localparam logic [CFG_W-1:0]  RST_EVEN_ONE = {{DATA_W{1'b0}}, FIX_ONE};
  localparam logic [CFG_W-1:0]  RST_ODD_ONE  = {FIX_ONE, {DATA_W{1'b0}}};

  typedef enum logic [IDX_W-1:0] {
    REG_R0_C01 = IDX_W'(0),
    REG_R0_C23 = IDX_W'(1),
    REG_R1_C01 = IDX_W'(2),
    REG_R1_C23 = IDX_W'(3),
    REG_R2_C01 = IDX_W'(4),
    REG_R2_C23 = IDX_W'(5),
    REG_R3_C01 = IDX_W'(6),
    REG_R3_C23 = IDX_W'(7)
  } vmt_reg_e;

  typedef logic [DATA_W-1:0] word_t;
  typedef word_t [DIM-1:0]   vec_t;
  // Indexed as [row][column].
  typedef vec_t [DIM-1:0]    mat_t;

  typedef logic [PROD_W-1:0]   prod_t;
  typedef prod_t [DIM-1:0]     prod_col_t;
  // Indexed as [column][row].
  typedef prod_col_t [DIM-1:0] prod_mat_t;

  typedef struct packed {
    vec_t pos;
    vec_t norm;
    logic with_normal;
    logic last;
  } vertex_t;

  typedef struct packed {
    prod_mat_t pos_p;
    prod_mat_t norm_p;
    vec_t      norm;
    logic      with_normal;
    logic      last;
  } prod_bundle_t;

  typedef struct packed {
    vec_t pos;
    vec_t norm;
    logic last;
  } result_t;

endpackage

>>> rtl/vmt_matrix_regs.sv
// Configuration registers holding the 4x4 transform matrix.
module vmt_matrix_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vmt_pkg::IDX_W-1:0]        cfg_index_i,
  input  logic [vmt_pkg::CFG_W-1:0]        cfg_data_i,
  output vmt_pkg::mat_t                    mat_o
);

  logic [vmt_pkg::CFG_W-1:0] regs_q [vmt_pkg::NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[vmt_pkg::SEL_W'(vmt_pkg::REG_R0_C01)] <= vmt_pkg::RST_EVEN_ONE;
      regs_q[vmt_pkg::SEL_W'(vmt_pkg::REG_R0_C23)] <= '0;
      regs_q[vmt_pkg::SEL_W'(vmt_pkg::REG_R1_C01)] <= vmt_pkg::RST_ODD_ONE;
      regs_q[vmt_pkg::SEL_W'(vmt_pkg::REG_R1_C23)] <= '0;
      regs_q[vmt_pkg::SEL_W'(vmt_pkg::REG_R2_C01)] <= '0;
      regs_q[vmt_pkg::SEL_W'(vmt_pkg::REG_R2_C23)] <= vmt_pkg::RST_EVEN_ONE;
      regs_q[vmt_pkg::SEL_W'(vmt_pkg::REG_R3_C01)] <= '0;
      regs_q[vmt_pkg::SEL_W'(vmt_pkg::REG_R3_C23)] <= vmt_pkg::RST_ODD_ONE;
    end else if (cfg_we_i && !cfg_index_i[vmt_pkg::IDX_W-1]) begin
      // Writes beyond the last register are dropped.
      regs_q[cfg_index_i[vmt_pkg::SEL_W-1:0]] <= cfg_data_i;
    end
  end

  // Each register carries an even column in its low half and an odd one above.
  always_comb begin
    for (int r = 0; r < vmt_pkg::DIM; r++) begin
      for (int c = 0; c < vmt_pkg::DIM; c++) begin
        mat_o[r][c] = regs_q[vmt_pkg::SEL_W'(2 * r + (c >> 1))]
                            [vmt_pkg::DATA_W * (c & 1) +: vmt_pkg::DATA_W];
      end
    end
  end

endmodule

>>> rtl/vmt_mul_stage.sv
// Input register and product stage: all vector-by-matrix products in parallel.
module vmt_mul_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  vmt_pkg::vertex_t      vertex_i,
  input  vmt_pkg::mat_t         mat_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output vmt_pkg::prod_bundle_t prod_o
);

  logic                  valid_a_q, valid_b_q;
  logic                  ready_a, ready_b;
  vmt_pkg::vertex_t      vtx_q;
  vmt_pkg::prod_bundle_t prod_q, prod_d;

  assign ready_b = !valid_b_q || ready_i;
  assign ready_a = !valid_a_q || ready_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a_q <= valid_i;
      end
      if (ready_b) begin
        valid_b_q <= valid_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      vtx_q <= vertex_i;
    end
    if (ready_b && valid_a_q) begin
      prod_q <= prod_d;
    end
  end

  // The normal sees the matrix with its translation entries taken as zero.
  always_comb begin
    logic signed [vmt_pkg::DATA_W-1:0] pv, nv, pm, nm;
    logic signed [vmt_pkg::PROD_W-1:0] pp, np;
    prod_d = '0;
    for (int c = 0; c < vmt_pkg::DIM; c++) begin
      for (int r = 0; r < vmt_pkg::DIM; r++) begin
        pv = vtx_q.pos[r];
        nv = vtx_q.norm[r];
        pm = mat_i[r][c];
        nm = (r == vmt_pkg::DIM - 1 && c < vmt_pkg::DIM - 1) ? '0 : mat_i[r][c];
        pp = pv * pm;
        np = nv * nm;
        prod_d.pos_p[c][r]  = pp;
        prod_d.norm_p[c][r] = np;
      end
    end
    prod_d.norm        = vtx_q.norm;
    prod_d.with_normal = vtx_q.with_normal;
    prod_d.last        = vtx_q.last;
  end

  assign ready_o = ready_a;
  assign valid_o = valid_b_q;
  assign prod_o  = prod_q;

endmodule

>>> rtl/vmt_sum_stage.sv
// Adder tree, fraction drop and saturation, ending in the output register.
module vmt_sum_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  vmt_pkg::prod_bundle_t prod_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output vmt_pkg::result_t      result_o
);

  typedef logic [vmt_pkg::PAIR_W-1:0] pair_t;
  typedef pair_t [1:0]                pair2_t;
  typedef pair2_t [vmt_pkg::DIM-1:0]  pair_vec_t;

  typedef struct packed {
    pair_vec_t     pos_s;
    pair_vec_t     norm_s;
    vmt_pkg::vec_t norm;
    logic          with_normal;
    logic          last;
  } pair_bundle_t;

  localparam int unsigned TOP_LO = vmt_pkg::FRAC_BITS + vmt_pkg::DATA_W - 1;

  logic             valid_c_q, valid_d_q;
  logic             ready_c, ready_d;
  pair_bundle_t     pair_q, pair_d;
  vmt_pkg::result_t res_q, res_d;

  // Drop the fraction bits (floor) and clamp to the signed word range.
  function automatic vmt_pkg::word_t sat_word(logic [vmt_pkg::SUM_W-1:0] total);
    logic [vmt_pkg::SUM_W-1-TOP_LO:0] top;
    vmt_pkg::word_t                   res;
    top = total[vmt_pkg::SUM_W-1:TOP_LO];
    if ((&top) || !(|top)) begin
      res = total[TOP_LO:vmt_pkg::FRAC_BITS];
    end else if (total[vmt_pkg::SUM_W-1]) begin
      res = {1'b1, {(vmt_pkg::DATA_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(vmt_pkg::DATA_W-1){1'b1}}};
    end
    return res;
  endfunction

  assign ready_d = !valid_d_q || ready_i;
  assign ready_c = !valid_c_q || ready_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
    end else begin
      if (ready_c) begin
        valid_c_q <= valid_i;
      end
      if (ready_d) begin
        valid_d_q <= valid_c_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_c && valid_i) begin
      pair_q <= pair_d;
    end
    if (ready_d && valid_c_q) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    logic signed [vmt_pkg::PAIR_W-1:0] ps0, ps1, ns0, ns1;
    pair_d = '0;
    for (int c = 0; c < vmt_pkg::DIM; c++) begin
      ps0 = $signed(prod_i.pos_p[c][0]) + $signed(prod_i.pos_p[c][1]);
      ps1 = $signed(prod_i.pos_p[c][2]) + $signed(prod_i.pos_p[c][3]);
      ns0 = $signed(prod_i.norm_p[c][0]) + $signed(prod_i.norm_p[c][1]);
      ns1 = $signed(prod_i.norm_p[c][2]) + $signed(prod_i.norm_p[c][3]);
      pair_d.pos_s[c][0]  = ps0;
      pair_d.pos_s[c][1]  = ps1;
      pair_d.norm_s[c][0] = ns0;
      pair_d.norm_s[c][1] = ns1;
    end
    pair_d.norm        = prod_i.norm;
    pair_d.with_normal = prod_i.with_normal;
    pair_d.last        = prod_i.last;
  end

  always_comb begin
    logic signed [vmt_pkg::SUM_W-1:0] pt, nt;
    res_d = '0;
    for (int c = 0; c < vmt_pkg::DIM; c++) begin
      pt = $signed(pair_q.pos_s[c][0]) + $signed(pair_q.pos_s[c][1]);
      nt = $signed(pair_q.norm_s[c][0]) + $signed(pair_q.norm_s[c][1]);
      res_d.pos[c]  = sat_word(pt);
      res_d.norm[c] = pair_q.with_normal ? sat_word(nt) : pair_q.norm[c];
    end
    res_d.last = pair_q.last;
  end

  assign ready_o  = ready_c;
  assign valid_o  = valid_d_q;
  assign result_o = res_q;

endmodule

>>> rtl/vertex_matrix_transform.sv
// Top level of the fixed-point 4x4 vertex matrix transform.
//
//   channel  direction  handshake                  payload
//   vertex   in         in_valid_i / in_stall_o    pos_*_i, norm_*_i, with_normal_i,
//                                                  last_vertex_i
//   result   out        out_valid_o / out_stall_i  out_pos_*_o, out_norm_*_o, out_last_o
//   config   in         cfg_we_i                   cfg_index_i, cfg_data_i
//
// One vertex is taken every clock while in_stall_o is low; each request passes through the
// input register, products, pair sums and output register before its result is presented.
// The depth is set by the 32x32 multipliers and the 66-bit adder tree behind them.
// Reset empties the pipeline and loads the identity matrix.
// A stall on the result side holds the last stage; earlier stages keep moving
// into empty slots, and in_stall_o rises only once every stage is full.
`include "assert_macros.svh"

module vertex_matrix_transform (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vmt_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [vmt_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [vmt_pkg::DATA_W-1:0] pos_x_i,
  input  logic signed [vmt_pkg::DATA_W-1:0] pos_y_i,
  input  logic signed [vmt_pkg::DATA_W-1:0] pos_z_i,
  input  logic signed [vmt_pkg::DATA_W-1:0] pos_w_i,
  input  logic signed [vmt_pkg::DATA_W-1:0] norm_x_i,
  input  logic signed [vmt_pkg::DATA_W-1:0] norm_y_i,
  input  logic signed [vmt_pkg::DATA_W-1:0] norm_z_i,
  input  logic signed [vmt_pkg::DATA_W-1:0] norm_w_i,
  input  logic                          with_normal_i,
  input  logic                          last_vertex_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [vmt_pkg::DATA_W-1:0] out_pos_x_o,
  output logic signed [vmt_pkg::DATA_W-1:0] out_pos_y_o,
  output logic signed [vmt_pkg::DATA_W-1:0] out_pos_z_o,
  output logic signed [vmt_pkg::DATA_W-1:0] out_pos_w_o,
  output logic signed [vmt_pkg::DATA_W-1:0] out_norm_x_o,
  output logic signed [vmt_pkg::DATA_W-1:0] out_norm_y_o,
  output logic signed [vmt_pkg::DATA_W-1:0] out_norm_z_o,
  output logic signed [vmt_pkg::DATA_W-1:0] out_norm_w_o,
  output logic                          out_last_o
);

  vmt_pkg::mat_t         mat;
  vmt_pkg::vertex_t      vertex;
  vmt_pkg::prod_bundle_t prod;
  vmt_pkg::result_t      result;
  logic                  in_ready;
  logic                  prod_valid, prod_ready;

  assign vertex.pos         = {pos_w_i, pos_z_i, pos_y_i, pos_x_i};
  assign vertex.norm        = {norm_w_i, norm_z_i, norm_y_i, norm_x_i};
  assign vertex.with_normal = with_normal_i;
  assign vertex.last        = last_vertex_i;

  vmt_matrix_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mat_o       (mat)
  );

  vmt_mul_stage u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready),
    .vertex_i (vertex),
    .mat_i    (mat),
    .valid_o  (prod_valid),
    .ready_i  (prod_ready),
    .prod_o   (prod)
  );

  vmt_sum_stage u_sum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (prod_valid),
    .ready_o  (prod_ready),
    .prod_i   (prod),
    .valid_o  (out_valid_o),
    .ready_i  (!out_stall_i),
    .result_o (result)
  );

  assign in_stall_o   = !in_ready;
  assign out_pos_x_o  = result.pos[0];
  assign out_pos_y_o  = result.pos[1];
  assign out_pos_z_o  = result.pos[2];
  assign out_pos_w_o  = result.pos[3];
  assign out_norm_x_o = result.norm[0];
  assign out_norm_y_o = result.norm[1];
  assign out_norm_z_o = result.norm[2];
  assign out_norm_w_o = result.norm[3];
  assign out_last_o   = result.last;

  // The pipeline only pushes back once the output is full and held.
  `VMT_ASSERT_ALWAYS(a_stall_only_when_full, in_stall_o |-> out_valid_o && out_stall_i, "input stalled with room in the pipeline")
  `VMT_ASSERT(a_prod_holds, prod_valid && !prod_ready |=> prod_valid && $stable(prod.last), "product stage lost a held request")
  `VMT_ASSERT(a_cfg_m33, cfg_we_i && cfg_index_i == vmt_pkg::REG_R3_C23 |=> mat[vmt_pkg::DIM-1][vmt_pkg::DIM-1] == $past(cfg_data_i[vmt_pkg::CFG_W-1:vmt_pkg::DATA_W]), "matrix entry M33 not taken from its register")

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the vertex matrix transform: directed table, then random phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vmt_pkg::*;

  localparam int unsigned ACC_W           = SUM_W + 2;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 80;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES    = 20;

  localparam logic [IDX_W-1:0] FIRST_STRAY_IDX = IDX_W'(NUM_REGS);

  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam word_t NEG_ONE  = -FIX_ONE;
  // Translation used by the shifted identity matrix: 5.0, -3.0 and 0.5.
  localparam word_t TX = 32'h0005_0000;
  localparam word_t TY = 32'hFFFD_0000;
  localparam word_t TZ = 32'h0000_8000;

  // Vectors are written {w, z, y, x}.
  localparam vec_t ALL_MAX     = {4{WORD_MAX}};
  localparam vec_t ALL_MIN     = {4{WORD_MIN}};
  localparam vec_t ALL_NEG_LSB = '1;
  localparam vec_t MIXED       = {WORD_MIN, WORD_MAX, 32'hFFFF_FFFF, 32'h0000_0001};
  localparam vec_t SAMPLE_POS  = {FIX_ONE, 32'h0003_4000, 32'hFFFD_8000, FIX_ONE};
  localparam vec_t SAMPLE_NORM = {FIX_ONE, 32'h0003_0000, 32'h0002_0000, FIX_ONE};
  localparam vec_t UNIT_Y      = {32'h0, 32'h0, FIX_ONE, 32'h0};
  localparam vec_t ORIGIN      = {FIX_ONE, 32'h0, 32'h0, 32'h0};
  localparam vec_t EDGE_X      = {FIX_ONE, 32'h0, 32'h0, WORD_MAX};
  localparam vec_t MIN_W       = {WORD_MIN, 32'h0003_4000, 32'hFFFD_8000, FIX_ONE};

  typedef enum {PRESET_RESET, PRESET_MAX, PRESET_MIN, PRESET_SHIFT} preset_e;
  typedef enum {MAT_SMALL, MAT_FULL, MAT_EXTREME, MAT_AFFINE} matrix_style_e;

  typedef struct {
    preset_e preset;
    vertex_t vtx;
    bit      typed;
    result_t want;
  } directed_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  word_t            pos_x_i, pos_y_i, pos_z_i, pos_w_i;
  word_t            norm_x_i, norm_y_i, norm_z_i, norm_w_i;
  logic             with_normal_i;
  logic             last_vertex_i;
  logic             out_valid_o;
  logic             out_stall_i;
  word_t            out_pos_x_o, out_pos_y_o, out_pos_z_o, out_pos_w_o;
  word_t            out_norm_x_o, out_norm_y_o, out_norm_z_o, out_norm_w_o;
  logic             out_last_o;

  logic [CFG_W-1:0] matrix_regs [NUM_REGS];
  logic [CFG_W-1:0] staged_regs [NUM_REGS];
  result_t          transformed_q [$];
  directed_row_t    rows [$];
  int unsigned      mismatches;
  int unsigned      idle_cycles;
  bit               quiet;

  vertex_matrix_transform i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .pos_w_i       (pos_w_i),
    .norm_x_i      (norm_x_i),
    .norm_y_i      (norm_y_i),
    .norm_z_i      (norm_z_i),
    .norm_w_i      (norm_w_i),
    .with_normal_i (with_normal_i),
    .last_vertex_i (last_vertex_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_pos_x_o   (out_pos_x_o),
    .out_pos_y_o   (out_pos_y_o),
    .out_pos_z_o   (out_pos_z_o),
    .out_pos_w_o   (out_pos_w_o),
    .out_norm_x_o  (out_norm_x_o),
    .out_norm_y_o  (out_norm_y_o),
    .out_norm_z_o  (out_norm_z_o),
    .out_norm_w_o  (out_norm_w_o),
    .out_last_o    (out_last_o)
  );

  always #1 clk_i = ~clk_i;

  // Row vector times matrix; the exact sum is floored by FRAC_BITS and then saturated.
  function automatic vec_t matrix_product(vec_t v, bit drop_translation);
    vec_t                     res;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  scaled;
    logic signed [PROD_W-1:0] prod;
    logic signed [DATA_W-1:0] entry;
    logic [CFG_W-1:0]         reg_word;
    for (int col = 0; col < DIM; col++) begin
      acc = '0;
      for (int row = 0; row < DIM; row++) begin
        reg_word = matrix_regs[row * 2 + col / 2];
        entry    = (col % 2 == 1) ? reg_word[CFG_W-1:DATA_W] : reg_word[DATA_W-1:0];
        if (drop_translation && row == DIM - 1 && col < DIM - 1) begin
          entry = '0;
        end
        prod = $signed(v[row]) * entry;
        acc  = acc + prod;
      end
      scaled = acc >>> FRAC_BITS;
      if (scaled[ACC_W-1:DATA_W-1] == '0 || scaled[ACC_W-1:DATA_W-1] == '1) begin
        res[col] = scaled[DATA_W-1:0];
      end else begin
        res[col] = scaled[ACC_W-1] ? WORD_MIN : WORD_MAX;
      end
    end
    return res;
  endfunction

  function automatic result_t transform_vertex(vertex_t v);
    result_t res;
    res.pos  = matrix_product(v.pos, 1'b0);
    res.norm = v.with_normal ? matrix_product(v.norm, 1'b1) : v.norm;
    res.last = v.last;
    return res;
  endfunction

  // Mostly values within +-1024.0, so that sums stay in range; wide ones cover every bit.
  function automatic word_t rand_word(bit wide);
    if (wide) begin
      return word_t'($urandom);
    end
    return word_t'($urandom_range(0, (1 << 27) - 1)) - (word_t'(1) << 26);
  endfunction

  task automatic add_row(preset_e preset, vec_t pos, vec_t norm, logic with_normal,
                         logic last, bit typed, vec_t want_pos, vec_t want_norm);
    directed_row_t r;
    r.preset           = preset;
    r.vtx.pos          = pos;
    r.vtx.norm         = norm;
    r.vtx.with_normal  = with_normal;
    r.vtx.last         = last;
    r.typed            = typed;
    r.want.pos         = want_pos;
    r.want.norm        = want_norm;
    r.want.last        = last;
    rows.push_back(r);
  endtask

  task automatic check_word(string what, word_t want, word_t got);
    if (want !== got) begin
      $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic send_vertex(vertex_t v, bit typed, result_t want);
    in_valid_i    <= 1'b1;
    pos_x_i       <= v.pos[0];
    pos_y_i       <= v.pos[1];
    pos_z_i       <= v.pos[2];
    pos_w_i       <= v.pos[3];
    norm_x_i      <= v.norm[0];
    norm_y_i      <= v.norm[1];
    norm_z_i      <= v.norm[2];
    norm_w_i      <= v.norm[3];
    with_normal_i <= v.with_normal;
    last_vertex_i <= v.last;
    do @(posedge clk_i); while (in_stall_o);
    transformed_q.push_back(typed ? want : transform_vertex(v));
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
  endtask

  // Every request yields one result, so an empty store means the pipeline is empty.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (transformed_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic program_matrix(bit add_stray);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= vmt_reg_e'(i);
      cfg_data_i  <= staged_regs[i];
      @(posedge clk_i);
      matrix_regs[i] = staged_regs[i];
      @(negedge clk_i);
    end
    // A write beyond the last register must leave the matrix alone.
    if (add_stray) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= FIRST_STRAY_IDX + IDX_W'($urandom_range(0, NUM_REGS - 1));
      cfg_data_i  <= {$urandom, $urandom};
      @(posedge clk_i);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (transformed_q.size() == 0) begin
        $display("%0t ns: result with no request outstanding, expected none, got pos_x %h",
                 $time, out_pos_x_o);
        mismatches++;
      end else begin
        want = transformed_q.pop_front();
        check_word("out_pos_x", want.pos[0], out_pos_x_o);
        check_word("out_pos_y", want.pos[1], out_pos_y_o);
        check_word("out_pos_z", want.pos[2], out_pos_z_o);
        check_word("out_pos_w", want.pos[3], out_pos_w_o);
        check_word("out_norm_x", want.norm[0], out_norm_x_o);
        check_word("out_norm_y", want.norm[1], out_norm_y_o);
        check_word("out_norm_z", want.norm[2], out_norm_z_o);
        check_word("out_norm_w", want.norm[3], out_norm_w_o);
        check_word("out_last", word_t'(want.last), word_t'(out_last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("%0t ns: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned burst;
    @(negedge clk_i);
    forever begin
      if (quiet) begin
        out_stall_i <= 1'b0;
        @(negedge clk_i);
      end else begin
        burst = $urandom_range(1, 19);
        out_stall_i <= ($urandom_range(0, 2) == 0);
        repeat (burst) @(negedge clk_i);
      end
    end
  end

  initial begin
    vertex_t       v;
    bit            wide;
    preset_e       current;
    matrix_style_e style;
    int unsigned   row;
    int unsigned   col;
    word_t         entry;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    pos_x_i       = '0;
    pos_y_i       = '0;
    pos_z_i       = '0;
    pos_w_i       = '0;
    norm_x_i      = '0;
    norm_y_i      = '0;
    norm_z_i      = '0;
    norm_w_i      = '0;
    with_normal_i = 1'b0;
    last_vertex_i = 1'b0;
    out_stall_i   = 1'b0;
    quiet         = 1'b0;
    mismatches    = 0;
    idle_cycles   = 0;

    foreach (matrix_regs[i]) matrix_regs[i] = '0;
    matrix_regs[REG_R0_C01] = RST_EVEN_ONE;
    matrix_regs[REG_R1_C01] = RST_ODD_ONE;
    matrix_regs[REG_R2_C23] = RST_EVEN_ONE;
    matrix_regs[REG_R3_C23] = RST_ODD_ONE;

    // The identity after reset returns every vertex as it came in.
    add_row(PRESET_RESET, '0, '0, 1'b0, 1'b0, 1'b1, '0, '0);
    add_row(PRESET_RESET, ALL_MAX, ALL_MAX, 1'b1, 1'b1, 1'b1, ALL_MAX, ALL_MAX);
    add_row(PRESET_RESET, ALL_MIN, ALL_MIN, 1'b1, 1'b0, 1'b1, ALL_MIN, ALL_MIN);
    add_row(PRESET_RESET, ALL_MAX, ALL_MIN, 1'b0, 1'b1, 1'b1, ALL_MAX, ALL_MIN);
    add_row(PRESET_RESET, ALL_NEG_LSB, MIXED, 1'b1, 1'b0, 1'b1, ALL_NEG_LSB, MIXED);
    add_row(PRESET_RESET, MIXED, ALL_NEG_LSB, 1'b0, 1'b0, 1'b1, MIXED, ALL_NEG_LSB);
    add_row(PRESET_RESET, SAMPLE_POS, UNIT_Y, 1'b1, 1'b1, 1'b1, SAMPLE_POS, UNIT_Y);
    // Extreme matrices drive most sums past the range.
    add_row(PRESET_MAX, ALL_MAX, ALL_MAX, 1'b1, 1'b0, 1'b1, ALL_MAX, ALL_MAX);
    add_row(PRESET_MAX, ALL_MIN, ALL_MIN, 1'b1, 1'b1, 1'b1, ALL_MIN, ALL_MIN);
    add_row(PRESET_MAX, ALL_MAX, ALL_MIN, 1'b0, 1'b0, 1'b1, ALL_MAX, ALL_MIN);
    add_row(PRESET_MAX, '0, '0, 1'b1, 1'b0, 1'b1, '0, '0);
    add_row(PRESET_MAX, SAMPLE_POS, MIXED, 1'b1, 1'b1, 1'b0, '0, '0);
    add_row(PRESET_MIN, ALL_MAX, ALL_MAX, 1'b1, 1'b0, 1'b1, ALL_MIN, ALL_MIN);
    add_row(PRESET_MIN, ALL_MIN, ALL_MIN, 1'b1, 1'b1, 1'b1, ALL_MAX, ALL_MAX);
    add_row(PRESET_MIN, SAMPLE_POS, UNIT_Y, 1'b1, 1'b0, 1'b0, '0, '0);
    // The translation moves the position but never the normal.
    add_row(PRESET_SHIFT, ORIGIN, SAMPLE_NORM, 1'b1, 1'b0, 1'b1,
            {FIX_ONE, TZ, TY, TX}, SAMPLE_NORM);
    add_row(PRESET_SHIFT, EDGE_X, '0, 1'b0, 1'b1, 1'b1, {FIX_ONE, TZ, TY, WORD_MAX}, '0);
    add_row(PRESET_SHIFT, SAMPLE_POS, SAMPLE_NORM, 1'b0, 1'b1, 1'b0, '0, '0);
    add_row(PRESET_SHIFT, MIN_W, MIXED, 1'b1, 1'b0, 1'b0, '0, '0);
    add_row(PRESET_SHIFT, ALL_NEG_LSB, ALL_MAX, 1'b1, 1'b1, 1'b0, '0, '0);

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    current = PRESET_RESET;
    foreach (rows[i]) begin
      if (rows[i].preset != current) begin
        drain();
        case (rows[i].preset)
          PRESET_MAX: foreach (staged_regs[k]) staged_regs[k] = {WORD_MAX, WORD_MAX};
          PRESET_MIN: foreach (staged_regs[k]) staged_regs[k] = {WORD_MIN, WORD_MIN};
          default: begin
            staged_regs[REG_R0_C01] = RST_EVEN_ONE;
            staged_regs[REG_R0_C23] = '0;
            staged_regs[REG_R1_C01] = RST_ODD_ONE;
            staged_regs[REG_R1_C23] = '0;
            staged_regs[REG_R2_C01] = '0;
            staged_regs[REG_R2_C23] = RST_EVEN_ONE;
            staged_regs[REG_R3_C01] = {TY, TX};
            staged_regs[REG_R3_C23] = {FIX_ONE, TZ};
          end
        endcase
        program_matrix(rows[i].preset == PRESET_SHIFT);
        current = rows[i].preset;
      end
      idle_gap();
      send_vertex(rows[i].vtx, rows[i].typed, rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      style = matrix_style_e'(p % 4);
      drain();
      for (int k = 0; k < NUM_REGS; k++) begin
        for (int h = 0; h < 2; h++) begin
          row = k / 2;
          col = (k % 2) * 2 + h;
          case (style)
            MAT_SMALL:  entry = word_t'($urandom_range(0, (1 << 19) - 1)) - (word_t'(1) << 18);
            MAT_FULL:   entry = word_t'($urandom);
            MAT_EXTREME: begin
              case ($urandom_range(0, 4))
                0:       entry = '0;
                1:       entry = WORD_MAX;
                2:       entry = WORD_MIN;
                3:       entry = FIX_ONE;
                default: entry = NEG_ONE;
              endcase
            end
            default:    entry = (row == col) ? FIX_ONE : (row == DIM - 1) ? rand_word(1'b0) : '0;
          endcase
          staged_regs[k][h*DATA_W +: DATA_W] = entry;
        end
      end
      // The last phase runs with neither side holding off.
      quiet = (p == PHASES - 1);
      program_matrix(1'($urandom_range(0, 1)));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        idle_gap();
        wide = ($urandom_range(0, 3) == 0);
        for (int c = 0; c < DIM; c++) begin
          v.pos[c]  = rand_word(wide);
          v.norm[c] = rand_word(wide);
        end
        if (!wide && $urandom_range(0, 1) == 1) begin
          v.pos[DIM-1] = FIX_ONE;
        end
        v.with_normal = 1'($urandom_range(0, 1));
        v.last        = ($urandom_range(0, 7) == 0);
        send_vertex(v, 1'b0, '0);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
